/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the frame parser RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define HFPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Check that a condition implies a consequence in the same cycle, outside reset.
`define HFPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`endif

/* hw/rtl/hfpd_pkg.sv */
// Shared types and constants of the HMI frame parser and decoder.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package hfpd_pkg;

    // Width that holds any frame length and the run limit.
    localparam int LenW = 7;
    localparam int CountW = 6;
    localparam int HDR_LEN = 6;

    localparam logic [CountW-1:0] RUN_LIMIT = 6'd32;
    localparam logic [7:0] TERM_BYTE = 8'hFF;
    localparam logic [1:0] HELD_LAST = 2'd2;

    localparam logic [7:0] CODE_TOUCH      = 8'h65;
    localparam logic [7:0] CODE_PAGE       = 8'h66;
    localparam logic [7:0] CODE_XY         = 8'h67;
    localparam logic [7:0] CODE_XY_SLEEP   = 8'h68;
    localparam logic [7:0] CODE_STRING     = 8'h70;
    localparam logic [7:0] CODE_NUMBER     = 8'h71;
    localparam logic [7:0] CODE_SLEEP      = 8'h86;
    localparam logic [7:0] CODE_WAKEUP     = 8'h87;
    localparam logic [7:0] CODE_STARTUP    = 8'h88;
    localparam logic [7:0] CODE_TFINISHED  = 8'hFD;
    localparam logic [7:0] CODE_TREADY     = 8'hFE;
    localparam logic [7:0] CODE_STATUS_MAX = 8'h24;

    localparam logic [LenW-1:0] LEN_TOUCH  = 7'd4;
    localparam logic [LenW-1:0] LEN_PAGE   = 7'd2;
    localparam logic [LenW-1:0] LEN_XY     = 7'd6;
    localparam logic [LenW-1:0] LEN_NUMBER = 7'd5;

    typedef enum logic [3:0] {
        EV_TOUCH      = 4'd0,
        EV_PAGE       = 4'd1,
        EV_XY         = 4'd2,
        EV_STRING     = 4'd3,
        EV_NUMBER     = 4'd4,
        EV_SLEEP      = 4'd5,
        EV_WAKEUP     = 4'd6,
        EV_STARTUP    = 4'd7,
        EV_TFINISHED  = 4'd8,
        EV_TREADY     = 4'd9,
        EV_STATUS     = 4'd10,
        EV_UNKNOWN    = 4'd11
    } event_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECODE,
        ST_RUN_RD,
        ST_RUN_LD,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic held_inc;
        logic store_ff;
        logic store_byte;
        logic frame_clear;
        logic load_single;
        logic start_run;
        logic run_read;
        logic load_run;
        logic run_next;
    } dp_cmd_t;

    typedef struct packed {
        logic byte_is_ff;
        logic held_two;
        logic held_nz;
        logic overflowed;
        logic fill_zero;
        logic dec_none;
        logic dec_run;
        logic run_more;
    } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/hfpd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the frame bytes of the parser.
`default_nettype none

module hfpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/hfpd_ctrl.sv */
// Controller state machine of the HMI frame parser: sequences byte storage,
// decode and result runs. Depends on hfpd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hfpd_ctrl import hfpd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (status.byte_is_ff) begin
                    if (status.held_two) begin
                        // Terminator: decode only a clean, non-empty frame.
                        if (status.overflowed || status.fill_zero) begin
                            cmd.frame_clear = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            state_next = ST_DECODE;
                        end
                    end else begin
                        cmd.held_inc = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (status.held_nz) begin
                    // Release one held 0xFF per cycle before the byte itself.
                    cmd.store_ff = 1'b1;
                end else begin
                    cmd.store_byte = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DECODE: begin
                cmd.frame_clear = 1'b1;
                if (status.dec_none) begin
                    state_next = ST_IDLE;
                end else if (status.dec_run) begin
                    cmd.start_run = 1'b1;
                    state_next = ST_RUN_RD;
                end else begin
                    cmd.load_single = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_RUN_RD: begin
                cmd.run_read = 1'b1;
                state_next = ST_RUN_LD;
            end
            ST_RUN_LD: begin
                cmd.load_run = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.run_more) begin
                        cmd.run_next = 1'b1;
                        state_next = ST_RUN_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `HFPD_ASSERT_IMPL(a_run_load_after_read, aclk, aresetn, state_reg == ST_RUN_LD, $past(state_reg) == ST_RUN_RD)

endmodule

`default_nettype wire

/* hw/rtl/hfpd_datapath.sv */
// Datapath of the HMI frame parser: frame store, hold-back counter, decode
// logic and result registers. Depends on hfpd_pkg, hfpd_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hfpd_datapath import hfpd_pkg::*; #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  s_rx_byte,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       status,
    output logic [3:0]       m_event_kind,
    output logic [7:0]       m_code_byte,
    output logic [7:0]       m_page_id,
    output logic [7:0]       m_comp_id,
    output logic             m_pressed,
    output logic [15:0]      m_x_pos,
    output logic [15:0]      m_y_pos,
    output logic             m_from_sleep,
    output logic [31:0]      m_number_value,
    output logic [7:0]       m_data_byte,
    output logic [5:0]       m_byte_count,
    output logic             m_last
);

    localparam int FW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = $clog2(MAX_PAYLOAD);

    logic [7:0]        byte_reg;
    logic [FW-1:0]     fill_reg;
    logic [FW-1:0]     fill_next;
    logic [1:0]        held_reg;
    logic [1:0]        held_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [7:0]        hdr_reg [HDR_LEN];

    event_kind_t       run_kind_reg;
    logic              run_start_reg;
    logic [CountW-1:0] run_cnt_reg;
    logic [CountW-1:0] k_reg;
    logic              run_active_reg;

    event_kind_t       m_event_kind_reg;
    logic [7:0]        m_code_byte_reg;
    logic [7:0]        m_page_id_reg;
    logic [7:0]        m_comp_id_reg;
    logic              m_pressed_reg;
    logic [15:0]       m_x_pos_reg;
    logic [15:0]       m_y_pos_reg;
    logic              m_from_sleep_reg;
    logic [31:0]       m_number_value_reg;
    logic [7:0]        m_data_byte_reg;
    logic [CountW-1:0] m_byte_count_reg;
    logic              m_last_reg;

    logic              full;
    logic              store_en;
    logic [7:0]        store_data;
    logic              ram_we;
    logic [LenW-1:0]   rd_sum;
    logic [7:0]        ram_rdata;

    logic [LenW-1:0]   len_ext;
    logic [7:0]        code;
    logic              dec_none;
    logic              dec_run;
    event_kind_t       dec_kind;
    logic              dec_start;
    logic [CountW-1:0] dec_cnt;
    logic              is_touch;
    logic              is_page;
    logic              is_xy;
    logic              is_number;

    function automatic logic [CountW-1:0] clip_count(input logic [LenW-1:0] n);
        logic [CountW-1:0] r;
        if (n > LenW'(RUN_LIMIT)) begin
            r = RUN_LIMIT;
        end else begin
            r = n[CountW-1:0];
        end
        return r;
    endfunction

    // Frame store and hold-back counter.
    assign full       = (fill_reg == FW'(MAX_PAYLOAD));
    assign store_en   = cmd.store_ff | cmd.store_byte;
    assign store_data = cmd.store_ff ? TERM_BYTE : byte_reg;
    assign ram_we     = store_en & ~full;

    always_comb begin
        fill_next = fill_reg;
        held_next = held_reg;
        ovf_next  = ovf_reg;
        if (cmd.frame_clear) begin
            fill_next = '0;
            held_next = '0;
            ovf_next  = 1'b0;
        end else begin
            if (cmd.held_inc) begin
                held_next = held_reg + 2'd1;
            end
            if (cmd.store_ff) begin
                held_next = held_reg - 2'd1;
            end
            if (store_en) begin
                // Drop a byte that finds the frame full.
                if (full) begin
                    ovf_next = 1'b1;
                end else begin
                    fill_next = fill_reg + FW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            held_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            held_reg <= held_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            byte_reg <= s_rx_byte;
        end
        // Keep a copy of the leading bytes for the fixed-layout events.
        for (int i = 0; i < HDR_LEN; i++) begin
            if (ram_we && (fill_reg == FW'(i))) begin
                hdr_reg[i] <= store_data;
            end
        end
    end

    assign rd_sum = LenW'(k_reg) + LenW'(run_start_reg);

    hfpd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (store_data),
        .rd_en   (cmd.run_read),
        .rd_addr (rd_sum[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // Decode of a completed frame by its first byte.
    assign len_ext = LenW'(fill_reg);
    assign code    = hdr_reg[0];

    always_comb begin
        dec_none  = 1'b0;
        dec_run   = 1'b0;
        dec_kind  = EV_UNKNOWN;
        dec_start = 1'b0;
        dec_cnt   = '0;
        is_touch  = 1'b0;
        is_page   = 1'b0;
        is_xy     = 1'b0;
        is_number = 1'b0;
        case (code)
            CODE_TOUCH: begin
                dec_kind = EV_TOUCH;
                is_touch = 1'b1;
                dec_none = (len_ext < LEN_TOUCH);
            end
            CODE_PAGE: begin
                dec_kind = EV_PAGE;
                is_page  = 1'b1;
                dec_none = (len_ext < LEN_PAGE);
            end
            CODE_XY, CODE_XY_SLEEP: begin
                dec_kind = EV_XY;
                is_xy    = 1'b1;
                dec_none = (len_ext < LEN_XY);
            end
            CODE_STRING: begin
                dec_kind  = EV_STRING;
                dec_start = 1'b1;
                dec_cnt   = clip_count(len_ext - LenW'(1));
                // A bare string code is one result with no payload.
                dec_run   = (dec_cnt != '0);
            end
            CODE_NUMBER: begin
                dec_kind  = EV_NUMBER;
                is_number = 1'b1;
                dec_none  = (len_ext < LEN_NUMBER);
            end
            CODE_SLEEP:     dec_kind = EV_SLEEP;
            CODE_WAKEUP:    dec_kind = EV_WAKEUP;
            CODE_STARTUP:   dec_kind = EV_STARTUP;
            CODE_TFINISHED: dec_kind = EV_TFINISHED;
            CODE_TREADY:    dec_kind = EV_TREADY;
            default: begin
                if ((len_ext == LenW'(1)) && (code <= CODE_STATUS_MAX)) begin
                    dec_kind = EV_STATUS;
                end else begin
                    dec_kind = EV_UNKNOWN;
                    dec_cnt  = clip_count(len_ext);
                    dec_run  = 1'b1;
                end
            end
        endcase
    end

    // Run bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_active_reg <= 1'b0;
        end else if (cmd.start_run) begin
            run_active_reg <= 1'b1;
        end else if (cmd.load_single) begin
            run_active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_run) begin
            run_kind_reg  <= dec_kind;
            run_start_reg <= dec_start;
            run_cnt_reg   <= dec_cnt;
            k_reg         <= '0;
        end else if (cmd.run_next) begin
            k_reg <= k_reg + CountW'(1);
        end
    end

    // Result registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_single) begin
            m_event_kind_reg   <= dec_kind;
            m_code_byte_reg    <= code;
            m_page_id_reg      <= (is_touch || is_page) ? hdr_reg[1] : 8'd0;
            m_comp_id_reg      <= is_touch ? hdr_reg[2] : 8'd0;
            m_pressed_reg      <= (is_touch && (hdr_reg[3] != 8'd0))
                                  || (is_xy && (hdr_reg[5] != 8'd0));
            m_x_pos_reg        <= is_xy ? {hdr_reg[1], hdr_reg[2]} : 16'd0;
            m_y_pos_reg        <= is_xy ? {hdr_reg[3], hdr_reg[4]} : 16'd0;
            m_from_sleep_reg   <= is_xy && (code == CODE_XY_SLEEP);
            m_number_value_reg <= is_number
                                  ? {hdr_reg[4], hdr_reg[3], hdr_reg[2], hdr_reg[1]}
                                  : 32'd0;
            m_data_byte_reg    <= 8'd0;
            m_byte_count_reg   <= '0;
            m_last_reg         <= 1'b1;
        end else if (cmd.load_run) begin
            m_event_kind_reg   <= run_kind_reg;
            m_code_byte_reg    <= code;
            m_page_id_reg      <= 8'd0;
            m_comp_id_reg      <= 8'd0;
            m_pressed_reg      <= 1'b0;
            m_x_pos_reg        <= 16'd0;
            m_y_pos_reg        <= 16'd0;
            m_from_sleep_reg   <= 1'b0;
            m_number_value_reg <= 32'd0;
            m_data_byte_reg    <= ram_rdata;
            m_byte_count_reg   <= run_cnt_reg;
            m_last_reg         <= ((k_reg + CountW'(1)) == run_cnt_reg);
        end
    end

    assign m_event_kind   = m_event_kind_reg;
    assign m_code_byte    = m_code_byte_reg;
    assign m_page_id      = m_page_id_reg;
    assign m_comp_id      = m_comp_id_reg;
    assign m_pressed      = m_pressed_reg;
    assign m_x_pos        = m_x_pos_reg;
    assign m_y_pos        = m_y_pos_reg;
    assign m_from_sleep   = m_from_sleep_reg;
    assign m_number_value = m_number_value_reg;
    assign m_data_byte    = m_data_byte_reg;
    assign m_byte_count   = m_byte_count_reg;
    assign m_last         = m_last_reg;

    always_comb begin
        status.byte_is_ff = (byte_reg == TERM_BYTE);
        status.held_two   = (held_reg == HELD_LAST);
        status.held_nz    = (held_reg != 2'd0);
        status.overflowed = ovf_reg;
        status.fill_zero  = (fill_reg == '0);
        status.dec_none   = dec_none;
        status.dec_run    = dec_run;
        status.run_more   = run_active_reg & ~m_last_reg;
    end

    `HFPD_ASSERT(a_held_below_term, aclk, aresetn, held_reg != 2'd3)
    `HFPD_ASSERT_IMPL(a_ovf_only_when_full, aclk, aresetn, ovf_reg, full)
    `HFPD_ASSERT_IMPL(a_run_index_in_range, aclk, aresetn, cmd.load_run, k_reg < run_cnt_reg)

endmodule

`default_nettype wire

/* hw/rtl/hmi_frame_parser_decoder.sv */
// Top level of the HMI frame parser and decoder.
// Depends on hfpd_pkg, hfpd_ctrl and hfpd_datapath.
//
// Usage:
//   The s_ channel takes one received serial byte per word (s_rx_byte).
//   Frames end with three 0xFF bytes; 0xFF bytes followed by other data
//   are stored as frame data. A completed, non-empty, non-overflowed frame
//   yields one event on the m_ channel, or none if it is too short for its
//   code's fixed layout; string events with payload and unknown events
//   yield a run of words, one payload byte each, with m_last on the final
//   word. A data byte passes through the idle and evaluate states, and the
//   evaluate state releases any held 0xFF bytes before storing it.
//   The state machine handles one byte at a time.
//   A single-word event is loaded in the decode state and is valid in the
//   output state. Each run word, the first after decode and each further
//   one once the previous is taken, passes through the RAM read and load states.
//   When the receiver stalls, the result word holds and s_ready stays low.
//   Reset (aresetn low, synchronous) empties the frame and drops held bytes.
`default_nettype none

module hmi_frame_parser_decoder import hfpd_pkg::*; #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_event_kind,
    output logic [7:0]       m_code_byte,
    output logic [7:0]       m_page_id,
    output logic [7:0]       m_comp_id,
    output logic             m_pressed,
    output logic [15:0]      m_x_pos,
    output logic [15:0]      m_y_pos,
    output logic             m_from_sleep,
    output logic [31:0]      m_number_value,
    output logic [7:0]       m_data_byte,
    output logic [5:0]       m_byte_count,
    output logic             m_last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    hfpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hfpd_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_rx_byte      (s_rx_byte),
        .cmd            (cmd),
        .status         (status),
        .m_event_kind   (m_event_kind),
        .m_code_byte    (m_code_byte),
        .m_page_id      (m_page_id),
        .m_comp_id      (m_comp_id),
        .m_pressed      (m_pressed),
        .m_x_pos        (m_x_pos),
        .m_y_pos        (m_y_pos),
        .m_from_sleep   (m_from_sleep),
        .m_number_value (m_number_value),
        .m_data_byte    (m_data_byte),
        .m_byte_count   (m_byte_count),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire
